### hw/rtl/pit_pkg.sv
// Package for the pedigree inbreeding path trace block.
// Holds widths, fixed-point constants and the controller/datapath command types.
`timescale 1ns / 1ps
package pit_pkg;
  localparam int MaxAnimals = 1024;
  localparam int AddrW = 10;
  localparam int IdW = 11;
  localparam int FW = 24;
  localparam int VW = 25;
  localparam int WW = 32;
  localparam int AccW = 40;
  localparam logic [VW-1:0] FxOne = 25'h1000000;
  localparam logic [VW-1:0] FxHalf = 25'h0800000;
  localparam logic [VW-1:0] FxThreeQ = 25'h0C00000;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StParent = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  typedef struct packed {
    logic take;        // latch input, read parent F
    logic store;       // compute d, write tables
    logic full;        // produce table-full result
    logic trace_init;  // set start weight, clear accumulator
    logic rd;          // read entry k
    logic proc;        // process entry k (weights present)
    logic sq;          // square registered
    logic acc;         // accumulate term
    logic upd_s;       // add to sire weight
    logic upd_d;       // add to dam weight
    logic step;        // k = k - 1
    logic finish;      // compute F, write F table, load output
    logic clr;         // clear one weight entry after reset
  } pit_cmd_t;

  typedef struct packed {
    logic both_known;
    logic count_full;
    logic k_zero;
    logic w_zero;
    logic s_valid;
    logic d_valid;
    logic clr_last;
  } pit_sts_t;
endpackage

### hw/rtl/pit_datapath.sv
// Datapath: pedigree tables, weight memory, squarer and accumulator.
// Depends on pit_pkg; steered by pit_ctrl through pit_cmd_t.
`timescale 1ns / 1ps
module pit_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pit_pkg::pit_cmd_t             cmd,
  output pit_pkg::pit_sts_t             sts,
  input  logic [pit_pkg::IdW-1:0]       in_sire_id,
  input  logic [pit_pkg::IdW-1:0]       in_dam_id,
  input  logic                          in_restart,
  output logic [pit_pkg::FW-1:0]        res_f,
  output logic [pit_pkg::VW-1:0]        res_v,
  output logic [pit_pkg::IdW-1:0]       res_idx,
  output logic [1:0]                    res_status
);
  logic [pit_pkg::IdW-1:0] sire_mem [pit_pkg::MaxAnimals];
  logic [pit_pkg::IdW-1:0] dam_mem [pit_pkg::MaxAnimals];
  logic [pit_pkg::VW-1:0] var_mem [pit_pkg::MaxAnimals];
  logic [pit_pkg::FW-1:0] f_mem [pit_pkg::MaxAnimals];
  logic [pit_pkg::WW-1:0] w_mem [pit_pkg::MaxAnimals];
  logic [pit_pkg::AddrW-1:0] clr_r;

  logic [pit_pkg::IdW-1:0] count_r, sid_r, did_r, k_r;
  logic [1:0] stat_r;
  logic [pit_pkg::FW-1:0] fs_r, fd_r;
  logic [pit_pkg::VW-1:0] var_r;
  logic [pit_pkg::IdW-1:0] ks_r, kd_r;
  logic [pit_pkg::VW-1:0] kv_r;
  logic [pit_pkg::WW-1:0] kw_r, pws_r, pwd_r;
  logic [pit_pkg::WW-1:0] sq_r;
  logic [pit_pkg::AccW-1:0] acc_r;

  logic [pit_pkg::IdW-1:0] cnt_eff, sid_c, did_c;
  logic [1:0] stat_c;
  logic [pit_pkg::AddrW-1:0] ka, sa, da, ra;
  logic [63:0] wsq;
  logic [56:0] term;
  logic [pit_pkg::AccW:0] acc_sum;
  logic [pit_pkg::WW:0] sum_s, sum_d;
  logic [pit_pkg::WW-1:0] half;
  logic [pit_pkg::FW+1:0] fsum;
  logic [pit_pkg::AccW-1:0] fval;
  logic [pit_pkg::FW-1:0] f_c;
  logic [pit_pkg::FW-1:0] fpar;

  assign cnt_eff = in_restart ? '0 : count_r;
  assign sid_c = (in_sire_id > cnt_eff) ? '0 : in_sire_id;
  assign did_c = (in_dam_id > cnt_eff) ? '0 : in_dam_id;
  assign stat_c = (in_sire_id > cnt_eff || in_dam_id > cnt_eff) ? pit_pkg::StParent
                                                               : pit_pkg::StOk;
  assign ka = k_r[pit_pkg::AddrW-1:0] - 1'b1;
  assign sa = ks_r[pit_pkg::AddrW-1:0] - 1'b1;
  assign da = kd_r[pit_pkg::AddrW-1:0] - 1'b1;
  assign ra = res_idx[pit_pkg::AddrW-1:0] - 1'b1;
  assign half = kw_r >> 1;
  assign wsq = kw_r * kw_r;
  assign term = sq_r * kv_r;
  assign acc_sum = {1'b0, acc_r} + {{(pit_pkg::AccW-32){1'b0}}, term[56:24]};
  assign sum_s = {1'b0, pws_r} + {1'b0, half};
  assign sum_d = {1'b0, pwd_r} + {1'b0, half};
  assign fsum = {2'b0, fs_r} + {2'b0, fd_r};
  assign fpar = (sid_r != '0) ? fs_r : fd_r;
  assign fval = acc_r - {{(pit_pkg::AccW-pit_pkg::VW){1'b0}}, pit_pkg::FxOne};
  always_comb begin
    if (acc_r <= {{(pit_pkg::AccW-pit_pkg::VW){1'b0}}, pit_pkg::FxOne}) f_c = '0;
    else if (fval > {{(pit_pkg::AccW-pit_pkg::FW){1'b0}}, {pit_pkg::FW{1'b1}}})
      f_c = {pit_pkg::FW{1'b1}};
    else f_c = fval[pit_pkg::FW-1:0];
  end

  assign sts.both_known = (sid_r != '0) && (did_r != '0);
  assign sts.count_full = (cnt_eff >= pit_pkg::IdW'(pit_pkg::MaxAnimals));
  assign sts.k_zero = (k_r == '0);
  assign sts.w_zero = (kw_r == '0);
  assign sts.s_valid = (ks_r != '0) && (ks_r < k_r);
  assign sts.d_valid = (kd_r != '0) && (kd_r < k_r);
  assign sts.clr_last = (clr_r == '1);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      sid_r <= sid_c;
      did_r <= did_c;
      stat_r <= stat_c;
      fs_r <= f_mem[sid_c[pit_pkg::AddrW-1:0] - 1'b1];
      fd_r <= f_mem[did_c[pit_pkg::AddrW-1:0] - 1'b1];
    end
    if (cmd.store) begin
      if (sts.both_known) var_r <= pit_pkg::FxHalf - {1'b0, fsum[pit_pkg::FW+1:2]};
      else if (sid_r != '0 || did_r != '0)
        var_r <= pit_pkg::FxThreeQ - {3'b0, fpar[pit_pkg::FW-1:2]};
      else var_r <= pit_pkg::FxOne;
    end
    if (cmd.store) begin
      sire_mem[count_r[pit_pkg::AddrW-1:0]] <= sid_r;
      dam_mem[count_r[pit_pkg::AddrW-1:0]] <= did_r;
    end
    if (cmd.finish) begin
      var_mem[ra] <= var_r;
      f_mem[ra] <= sts.both_known ? f_c : '0;
    end
    if (cmd.rd) begin
      ks_r <= sire_mem[ka];
      kd_r <= dam_mem[ka];
      kv_r <= (k_r == res_idx) ? var_r : var_mem[ka];
      kw_r <= w_mem[ka];
    end
    if (cmd.proc) begin
      pws_r <= w_mem[sa];
      pwd_r <= w_mem[da];
    end
    if (cmd.sq) sq_r <= (wsq[63:24] > 40'hFFFFFFFF) ? '1 : wsq[55:24];
    if (cmd.upd_s) w_mem[sa] <= sum_s[32] ? '1 : sum_s[31:0];
    else if (cmd.upd_d) w_mem[da] <= sum_d[32] ? '1 : sum_d[31:0];
    else if (cmd.trace_init) w_mem[count_r[pit_pkg::AddrW-1:0] - 1'b1] <= {7'b0, pit_pkg::FxOne};
    else if (cmd.step) w_mem[ka] <= '0;
    else if (cmd.clr) w_mem[clr_r] <= '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r <= '0;
      acc_r <= '0;
      clr_r <= '0;
      res_f <= '0;
      res_v <= '0;
      res_idx <= '0;
      res_status <= pit_pkg::StOk;
    end else begin
      if (cmd.clr) clr_r <= clr_r + 1'b1;
      if (cmd.take) count_r <= cnt_eff;
      if (cmd.full) begin
        res_f <= '0;
        res_v <= '0;
        res_idx <= '0;
        res_status <= pit_pkg::StFull;
      end
      if (cmd.store) begin
        count_r <= count_r + 1'b1;
        res_idx <= count_r + 1'b1;
        k_r <= count_r + 1'b1;
      end
      if (cmd.trace_init) acc_r <= '0;
      if (cmd.acc) acc_r <= acc_sum[pit_pkg::AccW] ? '1 : acc_sum[pit_pkg::AccW-1:0];
      if (cmd.step) k_r <= k_r - 1'b1;
      if (cmd.finish) begin
        res_f <= sts.both_known ? f_c : '0;
        res_v <= var_r;
        res_status <= stat_r;
      end
    end
  end
endmodule

### hw/rtl/pit_ctrl.sv
// Controller state machine for the path trace.
// Depends on pit_pkg; drives pit_datapath through pit_cmd_t.
`timescale 1ns / 1ps
module pit_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pit_pkg::pit_sts_t   sts,
  output pit_pkg::pit_cmd_t   cmd
);
  localparam logic [3:0] SIdle = 4'd0, SStore = 4'd1, SInit = 4'd2, SRd = 4'd3,
    SProc = 4'd4, SSq = 4'd5, SUpdS = 4'd6, SUpdD = 4'd7, SAcc = 4'd8,
    SStep = 4'd9, SFin = 4'd10, SOut = 4'd11, SRestore = 4'd12, SClr = 4'd13;
  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != SIdle);
  assign out_valid = (state_r == SOut);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      SClr: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = SIdle;
      end
      SIdle: if (in_valid) begin
        if (sts.count_full) begin
          cmd.full = 1'b1;
          state_nxt = SOut;
        end else begin
          cmd.take = 1'b1;
          state_nxt = SStore;
        end
      end
      SStore: begin
        cmd.store = 1'b1;
        state_nxt = sts.both_known ? SInit : SRestore;
      end
      SRestore: state_nxt = SFin;
      SInit: begin
        cmd.trace_init = 1'b1;
        state_nxt = SRd;
      end
      SRd: begin
        if (sts.k_zero) state_nxt = SFin;
        else begin
          cmd.rd = 1'b1;
          state_nxt = SProc;
        end
      end
      SProc: begin
        if (sts.w_zero) state_nxt = SStep;
        else begin
          cmd.proc = 1'b1;
          cmd.sq = 1'b1;
          state_nxt = SSq;
        end
      end
      SSq: begin
        cmd.upd_s = sts.s_valid;
        state_nxt = SUpdD;
      end
      SUpdD: begin
        cmd.proc = 1'b1;
        state_nxt = SUpdS;
      end
      SUpdS: begin
        cmd.upd_d = sts.d_valid;
        state_nxt = SAcc;
      end
      SAcc: begin
        cmd.acc = 1'b1;
        state_nxt = SStep;
      end
      SStep: begin
        cmd.step = 1'b1;
        state_nxt = SRd;
      end
      SFin: begin
        cmd.finish = 1'b1;
        state_nxt = SOut;
      end
      SOut: if (!out_stall) state_nxt = SIdle;
      default: state_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SClr;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != SIdle) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_take_store: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (state_r == SStore)) else $error("store skipped");
endmodule

### hw/rtl/pedigree_inbreeding_path_trace.sv
// Top level of the pedigree inbreeding path trace block.
// Depends on pit_pkg, pit_ctrl and pit_datapath.
//   channel | ports                                           | direction
//   input   | in_valid in_stall in_sire_id in_dam_id in_restart | in
//   result  | out_valid out_stall out_inbreeding out_sampling_variance
//           | out_animal_index out_status                      | out
// After reset the weight memory is cleared, all 1024 entries, with the input stalled.
// A full-table item goes straight to the result, and an animal with a parent
// unknown is stored and finished without a trace. A traced animal walks over
// stored entries k = index..1 with a read-modify-write of each known parent
// weight.
// Input is stalled from acceptance until the result is taken.
`timescale 1ns / 1ps
module pedigree_inbreeding_path_trace (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pit_pkg::IdW-1:0]       in_sire_id,
  input  logic [pit_pkg::IdW-1:0]       in_dam_id,
  input  logic                          in_restart,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pit_pkg::FW-1:0]        out_inbreeding,
  output logic [pit_pkg::VW-1:0]        out_sampling_variance,
  output logic [pit_pkg::IdW-1:0]       out_animal_index,
  output logic [1:0]                    out_status
);
  pit_pkg::pit_cmd_t cmd;
  pit_pkg::pit_sts_t sts;

  pit_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  pit_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_sire_id(in_sire_id), .in_dam_id(in_dam_id), .in_restart(in_restart),
    .res_f(out_inbreeding), .res_v(out_sampling_variance),
    .res_idx(out_animal_index), .res_status(out_status)
  );
endmodule
